>>> hdl/jbl_pkg.sv
// shared types, character codes and helpers for the json byte lexer
package jbl_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_STR   = 2'd1,
    MODE_ESC   = 2'd2,
    MODE_IDENT = 2'd3
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_LBRACE   = 3'd0,
    KIND_RBRACE   = 3'd1,
    KIND_LBRACKET = 3'd2,
    KIND_RBRACKET = 3'd3,
    KIND_COMMA    = 3'd4,
    KIND_COLON    = 3'd5,
    KIND_STRING   = 3'd6,
    KIND_IDENT    = 3'd7
  } token_kind_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_RBRKT  = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  localparam int unsigned OUT_DATA_BITS = 48;
  localparam int unsigned OUT_USER_BITS = 4;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] line;
    logic [15:0] column;
    logic        carries;
    logic [7:0]  char_byte;
    logic        last;
    logic        err;
  } res_t;

  typedef struct packed {
    logic        hit;
    token_kind_t kind;
  } punct_t;

  function automatic punct_t punct_kind(input logic [7:0] b);
    punct_t p;
    p.hit = 1'b1;
    case (b)
      CH_LBRACE: p.kind = KIND_LBRACE;
      CH_RBRACE: p.kind = KIND_RBRACE;
      CH_LBRKT:  p.kind = KIND_LBRACKET;
      CH_RBRKT:  p.kind = KIND_RBRACKET;
      CH_COMMA:  p.kind = KIND_COMMA;
      CH_COLON:  p.kind = KIND_COLON;
      default: begin
        p.hit  = 1'b0;
        p.kind = KIND_LBRACE;
      end
    endcase
    return p;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic res_t make_res(input token_kind_t kind, input logic [15:0] line,
                                    input logic [15:0] column, input logic carries,
                                    input logic [7:0] ch, input logic last,
                                    input logic err);
    res_t r;
    r.kind      = kind;
    r.line      = line;
    r.column    = column;
    r.carries   = carries;
    r.char_byte = carries ? ch : 8'h00;
    r.last      = last;
    r.err       = err;
    return r;
  endfunction

endpackage

>>> hdl/json_byte_lexer_unit.sv
// json byte lexer: text byte stream in, token word stream with positions out
//
// in_*  : one json text byte per word, in_tlast marks the last byte of a text
// out_* : token words; tuser gives the token kind and whether char_out is valid,
//         tlast marks the last word of a token, tdata carries line, column,
//         value byte and the open-string error flag
// path: a taken byte is held in the input register, lexed there, and its words
//   are appended to the output queue once it has room; out_tvalid comes from
//   the queue count
// throughput: one byte per cycle while out_tready stays high; the output side
//   drains one word per cycle, so a byte that gives two words (identifier closed
//   by a delimiter, string cut off after content) waits until both words fit
// stall: with out_tready low the queue fills, the input register holds its
//   byte and in_tready drops; nothing is lost or repeated
// reset: rst_n low clears the lexer mode, line/column counters and the queue;
//   after a last byte the lexer returns to the same state for the next text
module json_byte_lexer_unit #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] text_byte
  input  logic                                in_tlast,   // final_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] start_line, [31:16] start_column, [39:32] char_out,
  // [40] open_string_error, [47:41] zero
  output logic [jbl_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // [2:0] token_kind, [3] carries_char
  output logic [jbl_pkg::OUT_USER_BITS-1:0]   out_tuser,
  output logic                                out_tlast   // token_last
);
  import jbl_pkg::*;

  // input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       if_r;

  // lexer state
  lex_mode_t              mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] tcol_r, tcol_nxt;

  // two-word output queue, slot 0 is the head
  res_t       q_r [2];
  res_t       q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;

  // words produced by the byte in the input register
  res_t       res0, res1;
  logic [1:0] res_n;
  logic       nl;

  logic       pop;
  logic       adv;
  logic [1:0] free_slots;
  logic [1:0] cnt_pop;

  logic [15:0] cur_line16, cur_col16, tok_line16, tok_col16;
  punct_t      pk;
  logic        printable;

  assign cur_line16 = sat16(32'(line_r));
  assign cur_col16  = sat16(32'(col_r));
  assign tok_line16 = sat16(32'(tline_r));
  assign tok_col16  = sat16(32'(tcol_r));
  assign pk         = punct_kind(ib_r);
  assign printable  = ib_r inside {[8'd33:8'd126]};

  // handshake: take a byte whenever the input register is empty or empties this cycle
  assign pop        = out_tvalid && out_tready;
  assign free_slots = 2'd2 - cnt_r + {1'b0, pop};
  assign adv        = iv_r && (res_n <= free_slots);
  assign in_tready  = !iv_r || adv;

  // next lexer state
  always_comb begin
    mode_nxt  = mode_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    nl        = 1'b0;
    case (mode_r)
      MODE_IDLE: begin
        if (pk.hit) begin
          mode_nxt = MODE_IDLE;
        end else if (ib_r == CH_QUOTE) begin
          mode_nxt  = MODE_STR;
          tline_nxt = line_r;
          tcol_nxt  = col_r;
        end else if (ib_r == CH_NL) begin
          nl = 1'b1;
        end else if (printable) begin
          mode_nxt  = MODE_IDENT;
          tline_nxt = line_r;
          tcol_nxt  = col_r;
        end
      end
      MODE_STR: begin
        if (ib_r == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (ib_r == CH_QUOTE) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_STR;
      end
      MODE_IDENT: begin
        if (pk.hit) begin
          mode_nxt = MODE_IDLE;
        end else if (ib_r == CH_NL) begin
          mode_nxt = MODE_IDLE;
          nl       = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    if (if_r) begin
      // end of text: back to the start of a fresh text
      mode_nxt  = MODE_IDLE;
      line_nxt  = '0;
      col_nxt   = '0;
      tline_nxt = '0;
      tcol_nxt  = '0;
    end else if (nl) begin
      line_nxt = (line_r == '1) ? line_r : line_r + 1'b1;
      col_nxt  = '0;
    end else begin
      line_nxt = line_r;
      col_nxt  = (col_r == '1) ? col_r : col_r + 1'b1;
    end
  end

  // result words
  always_comb begin
    res0  = make_res(KIND_STRING, tok_line16, tok_col16, 1'b0, ib_r, 1'b1, 1'b1);
    res1  = make_res(KIND_STRING, tok_line16, tok_col16, 1'b0, ib_r, 1'b1, 1'b1);
    res_n = 2'd0;
    case (mode_r)
      MODE_IDLE: begin
        if (pk.hit) begin
          res0  = make_res(pk.kind, cur_line16, cur_col16, 1'b0, ib_r, 1'b1, 1'b0);
          res_n = 2'd1;
        end else if (ib_r == CH_QUOTE) begin
          // string opened on the last byte: error word at the quote
          res0  = make_res(KIND_STRING, cur_line16, cur_col16, 1'b0, ib_r, 1'b1, 1'b1);
          res_n = if_r ? 2'd1 : 2'd0;
        end else if (ib_r != CH_NL && printable) begin
          res0  = make_res(KIND_IDENT, cur_line16, cur_col16, 1'b1, ib_r, if_r, 1'b0);
          res_n = 2'd1;
        end
      end
      MODE_STR: begin
        if (ib_r == CH_BSLASH) begin
          res_n = if_r ? 2'd1 : 2'd0;
        end else if (ib_r == CH_QUOTE) begin
          res0  = make_res(KIND_STRING, tok_line16, tok_col16, 1'b0, ib_r, 1'b1, 1'b0);
          res_n = 2'd1;
        end else begin
          res0  = make_res(KIND_STRING, tok_line16, tok_col16, 1'b1, ib_r, 1'b0, 1'b0);
          res_n = if_r ? 2'd2 : 2'd1;
        end
      end
      MODE_ESC: begin
        // escaped byte passes through literally
        res0  = make_res(KIND_STRING, tok_line16, tok_col16, 1'b1, ib_r, 1'b0, 1'b0);
        res_n = if_r ? 2'd2 : 2'd1;
      end
      MODE_IDENT: begin
        if (pk.hit) begin
          res0  = make_res(KIND_IDENT, tok_line16, tok_col16, 1'b0, ib_r, 1'b1, 1'b0);
          res1  = make_res(pk.kind, cur_line16, cur_col16, 1'b0, ib_r, 1'b1, 1'b0);
          res_n = 2'd2;
        end else if (ib_r == CH_NL) begin
          res0  = make_res(KIND_IDENT, tok_line16, tok_col16, 1'b0, ib_r, 1'b1, 1'b0);
          res_n = 2'd1;
        end else begin
          res0  = make_res(KIND_IDENT, tok_line16, tok_col16, 1'b1, ib_r, if_r, 1'b0);
          res_n = 2'd1;
        end
      end
      default: begin
        res_n = 2'd0;
      end
    endcase
  end

  // queue update: drop the head on a pop, then append the new words
  always_comb begin
    q_nxt   = q_r;
    cnt_pop = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_pop  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_pop;
    if (adv) begin
      if (res_n != 2'd0) begin
        q_nxt[cnt_pop[0]] = res0;
      end
      if (res_n == 2'd2) begin
        q_nxt[1] = res1;
      end
      cnt_nxt = cnt_pop + res_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r    <= 1'b0;
      mode_r  <= MODE_IDLE;
      line_r  <= '0;
      col_r   <= '0;
      tline_r <= '0;
      tcol_r  <= '0;
      cnt_r   <= 2'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        iv_r <= 1'b1;
      end else if (adv) begin
        iv_r <= 1'b0;
      end
      if (adv) begin
        mode_r  <= mode_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
        tline_r <= tline_nxt;
        tcol_r  <= tcol_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ib_r <= in_tdata;
      if_r <= in_tlast;
    end
    q_r <= q_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {7'd0, q_r[0].err, q_r[0].char_byte, q_r[0].column, q_r[0].line};
  assign out_tuser  = {q_r[0].carries, q_r[0].kind};
  assign out_tlast  = q_r[0].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output queue overfilled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !out_tready) |-> !(adv && res_n != 2'd0))
    else $error("words appended to a full, stalled queue");

  a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && if_r) |=> (mode_r == MODE_IDLE && line_r == '0 && col_r == '0))
    else $error("lexer state not cleared after last byte");

  a_newline_col: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && nl) |=> (col_r == '0))
    else $error("column not cleared after newline");
`endif

endmodule

>>> verif/tb_json_byte_lexer_unit.sv
// self-checking testbench for json_byte_lexer_unit: directed and random text, scoreboard on tokens
module tb_json_byte_lexer_unit;
  import jbl_pkg::*;

  localparam int LINE_BITS    = 16;
  localparam int COLUMN_BITS  = 16;
  localparam int RANDOM_BYTES = 400;
  // longer than any quiet spell a correct run can have (random stalls are short)
  localparam int QUIET_LIMIT  = 1000;
  // output queue is two words deep
  localparam int TAIL_CYCLES  = 8;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // one text byte waiting to be sent
  typedef struct {
    logic [7:0] b;
    logic       fin;    // last byte of its text
    logic       calm;   // sent and drained with no random idling
    logic       drain;  // hold until every due token word has come back
  } text_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [OUT_USER_BITS-1:0] out_tuser;
  logic        out_tlast;

  text_byte_t  text_bytes_pending[$];
  res_t        token_words_due[$];

  // lexer state as the testbench sees it
  lex_mode_t              scan_mode = MODE_IDLE;
  logic [LINE_BITS-1:0]   line_cnt = '0;
  logic [COLUMN_BITS-1:0] col_cnt = '0;
  logic [LINE_BITS-1:0]   tok_line = '0;
  logic [COLUMN_BITS-1:0] tok_col = '0;

  logic        steady = 1'b0;
  logic        calm_now = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned words_checked = 0;
  int unsigned err_words = 0;
  int unsigned texts_built = 0;

  json_byte_lexer_unit #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // token prediction
  // ---------------------------------------------------------------------------

  // punctuation lookup; returns 1 and the kind when b is one of { } [ ] , :
  function automatic logic punct_of(input logic [7:0] b, output token_kind_t k);
    k = KIND_LBRACE;
    case (b)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRKT:  k = KIND_LBRACKET;
      CH_RBRKT:  k = KIND_RBRACKET;
      CH_COMMA:  k = KIND_COMMA;
      CH_COLON:  k = KIND_COLON;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // queue one expected token word; char is forced to zero when it carries none
  function automatic void due_word(input token_kind_t kind, input logic [15:0] line,
                                   input logic [15:0] column, input logic carries,
                                   input logic [7:0] ch, input logic last,
                                   input logic err);
    res_t w;
    w.kind      = kind;
    w.line      = line;
    w.column    = column;
    w.carries   = carries;
    w.char_byte = carries ? ch : 8'h00;
    w.last      = last;
    w.err       = err;
    token_words_due.push_back(w);
  endfunction

  // advance the lexer by one accepted text byte and queue the words it gives
  function automatic void lex_byte(input logic [7:0] b, input logic fin);
    token_kind_t pk;
    logic        hit;
    logic        nl;
    hit = punct_of(b, pk);
    nl  = 1'b0;
    case (scan_mode)
      MODE_IDLE: begin
        if (hit) begin
          due_word(pk, line_cnt, col_cnt, 1'b0, 8'h00, 1'b1, 1'b0);
        end else if (b == CH_QUOTE) begin
          tok_line  = line_cnt;
          tok_col   = col_cnt;
          scan_mode = MODE_STR;
          // a quote as the very last byte is an open string
          if (fin) due_word(KIND_STRING, line_cnt, col_cnt, 1'b0, 8'h00, 1'b1, 1'b1);
        end else if (b == CH_NL) begin
          nl = 1'b1;
        end else if (b > PRINT_LO && b < PRINT_HI) begin
          tok_line  = line_cnt;
          tok_col   = col_cnt;
          scan_mode = MODE_IDENT;
          due_word(KIND_IDENT, line_cnt, col_cnt, 1'b1, b, fin, 1'b0);
        end
        // anything else outside a token is skipped
      end
      MODE_STR: begin
        if (b == CH_BSLASH) begin
          scan_mode = MODE_ESC;
          if (fin) due_word(KIND_STRING, tok_line, tok_col, 1'b0, 8'h00, 1'b1, 1'b1);
        end else if (b == CH_QUOTE) begin
          due_word(KIND_STRING, tok_line, tok_col, 1'b0, 8'h00, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
        end else begin
          // newline is plain content here and does not bump the line
          due_word(KIND_STRING, tok_line, tok_col, 1'b1, b, 1'b0, 1'b0);
          if (fin) due_word(KIND_STRING, tok_line, tok_col, 1'b0, 8'h00, 1'b1, 1'b1);
        end
      end
      MODE_ESC: begin
        // escaped byte passes through as is
        due_word(KIND_STRING, tok_line, tok_col, 1'b1, b, 1'b0, 1'b0);
        scan_mode = MODE_STR;
        if (fin) due_word(KIND_STRING, tok_line, tok_col, 1'b0, 8'h00, 1'b1, 1'b1);
      end
      default: begin
        if (hit) begin
          // close the identifier, then the delimiter's own token
          due_word(KIND_IDENT, tok_line, tok_col, 1'b0, 8'h00, 1'b1, 1'b0);
          due_word(pk, line_cnt, col_cnt, 1'b0, 8'h00, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
        end else if (b == CH_NL) begin
          due_word(KIND_IDENT, tok_line, tok_col, 1'b0, 8'h00, 1'b1, 1'b0);
          scan_mode = MODE_IDLE;
          nl = 1'b1;
        end else begin
          due_word(KIND_IDENT, tok_line, tok_col, 1'b1, b, fin, 1'b0);
        end
      end
    endcase
    // position update, saturating; the last byte of a text starts over
    if (fin) begin
      scan_mode = MODE_IDLE;
      line_cnt  = '0;
      col_cnt   = '0;
      tok_line  = '0;
      tok_col   = '0;
    end else if (nl) begin
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
      col_cnt = '0;
    end else if (col_cnt != '1) begin
      col_cnt = col_cnt + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic void put(input logic [7:0] b);
    text_byte_t t;
    t.b     = b;
    t.fin   = 1'b0;
    t.calm  = calm_now;
    t.drain = 1'b0;
    text_bytes_pending.push_back(t);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void end_text();
    text_bytes_pending[text_bytes_pending.size()-1].fin = 1'b1;
    texts_built++;
  endfunction

  // filler between tokens: spaces, tabs, newlines, control and high bytes
  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_NL;
      3:       return 8'($urandom_range(127, 255));
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  // one random text: mostly well formed tokens, with noise and cut-off strings
  function automatic void build_random_text();
    token_kind_t k;
    logic [7:0]  c;
    repeat ($urandom_range(1, 12)) begin
      repeat ($urandom_range(0, 2)) put(blank_byte());
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          case ($urandom_range(0, 5))
            0:       put(CH_LBRACE);
            1:       put(CH_RBRACE);
            2:       put(CH_LBRKT);
            3:       put(CH_RBRKT);
            4:       put(CH_COMMA);
            default: put(CH_COLON);
          endcase
        end
        3, 4, 5: begin
          put(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 5) == 0) begin
              put(CH_BSLASH);
              put(8'($urandom_range(0, 255)));
            end else begin
              c = 8'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(97, 122));
              if (c == CH_QUOTE || c == CH_BSLASH) c = "s";
              put(c);
            end
          end
          // now and then the string is left open
          if ($urandom_range(0, 9) != 0) put(CH_QUOTE);
        end
        6, 7, 8: begin
          c = 8'($urandom_range(33, 126));
          while (punct_of(c, k) || c == CH_QUOTE) c = 8'($urandom_range(33, 126));
          put(c);
          repeat ($urandom_range(0, 6)) begin
            c = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(97, 122));
            if (punct_of(c, k) || c == CH_NL) c = "_";
            put(c);
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
        end
      endcase
    end
    end_text();
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one text byte per word, held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_text
    logic launch;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        launch = text_bytes_pending.size() != 0 && (steady || $urandom_range(99) >= 22);
        // pressure point: wait for the block to hand back everything first
        if (launch && text_bytes_pending[0].drain && token_words_due.size() != 0)
          launch = 1'b0;
        if (launch) begin
          in_tvalid <= 1'b1;
          in_tdata  <= text_bytes_pending[0].b;
          in_tlast  <= text_bytes_pending[0].fin;
          steady    <= text_bytes_pending[0].calm;
          void'(text_bytes_pending.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: compare each token word with the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_tokens
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_checked++;
        if (out_tdata[40]) err_words++;
        if (token_words_due.size() == 0) begin
          $error("token word with nothing expected: user %0h data %0h last %0b",
                 out_tuser, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = token_words_due.pop_front();
          check_field("token_kind", 16'(want.kind), 16'(out_tuser[2:0]));
          check_field("carries_char", 16'(want.carries), 16'(out_tuser[3]));
          check_field("start_line", want.line, out_tdata[15:0]);
          check_field("start_column", want.column, out_tdata[31:16]);
          check_field("char_out", 16'(want.char_byte), 16'(out_tdata[39:32]));
          check_field("open_string_error", 16'(want.err), 16'(out_tdata[40]));
          check_field("tdata_pad", 16'd0, 16'(out_tdata[47:41]));
          check_field("token_last", 16'(want.last), 16'(out_tlast));
        end
      end
      out_tready <= steady || ($urandom_range(99) >= 22);
    end
  end

  // cycles in a row with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("json_byte_lexer_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned base;
    // directed: all punctuation, escaped quote and newline in a string,
    // empty string, skipped bytes, identifier with a high byte closed by a
    // delimiter, identifier closed by newline, identifier at end of text
    put_text("{}[],:");
    put_text("\"a\\\"\n\"");
    put_text("\"\"");
    put(8'h00);
    put(8'hFF);
    put(CH_NL);
    put_text("!");
    put(8'h80);
    put_text(":~\nz");
    end_text();
    // texts that end inside a string: after content, on a backslash,
    // on the opening quote, right after an escaped byte
    put_text("\"q");
    end_text();
    put_text("\"\\");
    end_text();
    put_text("\"");
    end_text();
    put_text("\"\\x");
    end_text();

    // random texts; the third starts only once the block has drained,
    // random texts four to seven run with no idling on either side
    base = text_bytes_pending.size();
    while (text_bytes_pending.size() - base < RANDOM_BYTES) begin
      calm_now = (texts_built >= 8 && texts_built < 12);
      if (texts_built == 10) begin
        build_random_text();
        text_bytes_pending[text_bytes_pending.size()-1].fin = 1'b1;
      end else begin
        build_random_text();
      end
      if (texts_built == 7)
        put(CH_SPACE);
      if (texts_built == 7)
        text_bytes_pending[text_bytes_pending.size()-1].drain = 1'b1;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (text_bytes_pending.size() != 0 || in_tvalid) @(posedge clk);
    while (token_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (token_words_due.size() != 0) begin
      $error("%0d token words never arrived", token_words_due.size());
      fail_count++;
    end

    $display("sent %0d text bytes in %0d texts, checked %0d token words",
             bytes_taken, texts_built, words_checked);
    $display("incl. %0d open-string errors, a drain pause and a run with no idling",
             err_words);
    if (fail_count == 0) begin
      $display("json_byte_lexer_unit regression: pass");
    end else begin
      $display("json_byte_lexer_unit regression: fail");
    end
    $finish;
  end

endmodule
